// ===== design/arbf_pkg.sv =====
// Shared types, codes and constants of the aligned record boot framer.
package arbf_pkg;

	localparam int DEFAULT_RECORD_ALIGN = 16;
	localparam int DEFAULT_QUEUE_DEPTH = 4;

	localparam int CFG_INDEX_W = 2;
	localparam int ADDR_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_PROGRAM_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ADDRESS = 2'd1;

	localparam logic [ADDR_W-1:0] RESET_LENGTH = 16'd1;
	localparam logic [ADDR_W-1:0] RESET_ADDRESS = 16'h1000;

	localparam logic [7:0] CHAR_LEADER = 8'hFF;
	localparam logic [7:0] CHAR_S = 8'h53;
	localparam logic [7:0] CHAR_ONE = 8'h31;
	localparam logic [7:0] CHAR_J = 8'h4A;

	localparam logic [2:0] ROLE_LEADER = 3'd0;
	localparam logic [2:0] ROLE_MARK = 3'd1;
	localparam logic [2:0] ROLE_COUNT = 3'd2;
	localparam logic [2:0] ROLE_ADDR_HI = 3'd3;
	localparam logic [2:0] ROLE_ADDR_LO = 3'd4;
	localparam logic [2:0] ROLE_DATA = 3'd5;
	localparam logic [2:0] ROLE_CHECKSUM = 3'd6;
	localparam logic [2:0] ROLE_END = 3'd7;

	// One classified program byte: which groups of stream bytes it causes.
	typedef struct packed {
		logic       leader;
		logic       hdr;
		logic       has_data;
		logic       has_ck;
		logic       has_end;
		logic [7:0] cnt;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] data;
		logic [7:0] ck;
	} cmd_t;

endpackage

// ===== design/arbf_front.sv =====
// Front end: takes program bytes and configuration, tracks records, builds commands.
module arbf_front import arbf_pkg::*; #(
	parameter int RECORD_ALIGN = DEFAULT_RECORD_ALIGN
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data,
	input  logic                   q_full,
	output logic                   q_push,
	output cmd_t                   q_cmd
);

	localparam int OFS_W = $clog2(RECORD_ALIGN);
	localparam int RECIP = 65536 / RECORD_ALIGN;
	localparam logic [ADDR_W-1:0] ALIGN16 = ADDR_W'(RECORD_ALIGN);
	localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(RECORD_ALIGN - 1);
	localparam logic [OFS_W-1:0] RESET_OFS = OFS_W'(RESET_ADDRESS % RECORD_ALIGN);

	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] rem_q;
	logic [OFS_W-1:0]  ofs_q;
	logic [7:0]        rec_left_q;
	logic [7:0]        sum_q;
	logic              leader_sent_q;
	logic              fin_q;
	logic              busy_q;
	logic [31:0]       prod_q;

	logic              accept;
	logic              has_data;
	logic              hdr;
	logic [7:0]        to_edge;
	logic [7:0]        block;
	logic [7:0]        cnt;
	logic [7:0]        sum0;
	logic [7:0]        sum1;
	logic [7:0]        rec_left_nxt;
	logic [ADDR_W-1:0] rem_nxt;
	logic [ADDR_W-1:0] quot;
	logic [ADDR_W-1:0] rem_raw;
	logic [ADDR_W-1:0] rem_fix;

	assign in_stall = busy_q | q_full;
	assign accept = in_valid & ~in_stall;

	assign has_data = (rem_q != '0);
	assign hdr = has_data & (rec_left_q == '0);
	assign to_edge = 8'(RECORD_ALIGN) - 8'(ofs_q);
	assign block = ({8'd0, to_edge} > rem_q) ? rem_q[7:0] : to_edge;
	assign cnt = block + 8'd2;
	assign sum0 = hdr ? (cnt + addr_q[15:8] + addr_q[7:0]) : sum_q;
	assign sum1 = sum0 + data_byte;
	assign rec_left_nxt = (hdr ? block : rec_left_q) - 8'd1;
	assign rem_nxt = has_data ? (rem_q - 16'd1) : rem_q;

	// Address offset within the alignment after a load, by reciprocal multiply.
	assign quot = prod_q[31:16];
	assign rem_raw = addr_q - 16'(quot * ALIGN16);
	assign rem_fix = (rem_raw >= ALIGN16) ? (rem_raw - ALIGN16) : rem_raw;

	always_comb begin
		q_push = accept & ~fin_q;
		q_cmd.leader = ~leader_sent_q;
		q_cmd.hdr = hdr;
		q_cmd.has_data = has_data;
		q_cmd.has_ck = has_data & (rec_left_nxt == '0);
		q_cmd.has_end = (rem_nxt == '0);
		q_cmd.cnt = cnt;
		q_cmd.hi = addr_q[15:8];
		q_cmd.lo = addr_q[7:0];
		q_cmd.data = data_byte;
		q_cmd.ck = 8'd0 - sum1;
	end

	always_ff @(posedge clk) begin
		if (cfg_valid && cfg_index == REG_LOAD_ADDRESS) begin
			prod_q <= 32'(cfg_data) * 32'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= RESET_ADDRESS;
			rem_q <= RESET_LENGTH;
			ofs_q <= RESET_OFS;
			rec_left_q <= '0;
			sum_q <= '0;
			leader_sent_q <= 1'b0;
			fin_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			busy_q <= cfg_valid && !leader_sent_q && (cfg_index == REG_LOAD_ADDRESS);
			if (busy_q) begin
				ofs_q <= OFS_W'(rem_fix);
			end
			if (cfg_valid && !leader_sent_q) begin
				case (cfg_index)
					REG_PROGRAM_LENGTH: rem_q <= cfg_data;
					REG_LOAD_ADDRESS: begin
						addr_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (q_push) begin
				leader_sent_q <= 1'b1;
				if (q_cmd.has_end) begin
					fin_q <= 1'b1;
				end
				if (has_data) begin
					sum_q <= sum1;
					rec_left_q <= rec_left_nxt;
					rem_q <= rem_nxt;
					addr_q <= addr_q + 16'd1;
					// The offset restarts at every aligned boundary and at the address wrap.
					if (addr_q == '1 || ofs_q == OFS_MAX) begin
						ofs_q <= '0;
					end else begin
						ofs_q <= ofs_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== design/arbf_queue.sv =====
// Short command queue between the front end and the byte emitter.
module arbf_queue import arbf_pkg::*; #(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic avail,
	output cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_FULL);
	assign avail = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop = pop & avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/arbf_back.sv =====
// Back end: walks each command through its stream bytes, one byte per cycle while the output is not stalled.
module arbf_back import arbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_avail,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic [9:0] frame_bits,
	output logic [2:0] byte_role,
	output logic       last_of_run,
	output logic       stream_done
);

	localparam logic [3:0] PH_LEAD0 = 4'd0;
	localparam logic [3:0] PH_LEAD1 = 4'd1;
	localparam logic [3:0] PH_S = 4'd2;
	localparam logic [3:0] PH_ONE = 4'd3;
	localparam logic [3:0] PH_CNT = 4'd4;
	localparam logic [3:0] PH_HI = 4'd5;
	localparam logic [3:0] PH_LO = 4'd6;
	localparam logic [3:0] PH_DATA = 4'd7;
	localparam logic [3:0] PH_CK = 4'd8;
	localparam logic [3:0] PH_ES = 4'd9;
	localparam logic [3:0] PH_EJ = 4'd10;
	localparam logic [3:0] PH_NONE = 4'd15;

	function automatic logic [10:0] phase_mask(input cmd_t c);
		return {c.has_end, c.has_end, c.has_ck, c.has_data, {5{c.hdr}}, {2{c.leader}}};
	endfunction

	// Lowest enabled phase at or above the start phase.
	function automatic logic [3:0] first_from(input logic [10:0] m, input logic [3:0] s);
		logic [3:0] r;
		r = PH_NONE;
		for (int i = 10; i >= 0; i--) begin
			if (m[i] && 4'(i) >= s) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] ph_q;
	logic       out_valid_q;
	logic [7:0] tx_byte_q;
	logic [2:0] role_q;
	logic       last_q;
	logic       done_q;

	logic [3:0] nxt_ph;
	logic       last;
	logic       adv;
	logic [7:0] cur_byte;
	logic [2:0] cur_role;

	assign nxt_ph = first_from(phase_mask(cur_q), ph_q + 4'd1);
	assign last = (nxt_ph == PH_NONE);
	assign adv = cur_valid_q & (~out_valid_q | ~out_stall);
	assign q_pop = q_avail & (~cur_valid_q | (adv & last));

	always_comb begin
		case (ph_q)
			PH_LEAD0, PH_LEAD1: begin
				cur_byte = CHAR_LEADER;
				cur_role = ROLE_LEADER;
			end
			PH_S: begin
				cur_byte = CHAR_S;
				cur_role = ROLE_MARK;
			end
			PH_ONE: begin
				cur_byte = CHAR_ONE;
				cur_role = ROLE_MARK;
			end
			PH_CNT: begin
				cur_byte = cur_q.cnt;
				cur_role = ROLE_COUNT;
			end
			PH_HI: begin
				cur_byte = cur_q.hi;
				cur_role = ROLE_ADDR_HI;
			end
			PH_LO: begin
				cur_byte = cur_q.lo;
				cur_role = ROLE_ADDR_LO;
			end
			PH_DATA: begin
				cur_byte = cur_q.data;
				cur_role = ROLE_DATA;
			end
			PH_CK: begin
				cur_byte = cur_q.ck;
				cur_role = ROLE_CHECKSUM;
			end
			PH_ES: begin
				cur_byte = CHAR_S;
				cur_role = ROLE_END;
			end
			PH_EJ: begin
				cur_byte = CHAR_J;
				cur_role = ROLE_END;
			end
			default: begin
				cur_byte = CHAR_LEADER;
				cur_role = ROLE_LEADER;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (adv) begin
			tx_byte_q <= cur_byte;
			role_q <= cur_role;
			last_q <= last;
			done_q <= (ph_q == PH_EJ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			ph_q <= PH_LEAD0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				ph_q <= first_from(phase_mask(q_cmd), PH_LEAD0);
			end else if (adv) begin
				if (last) begin
					cur_valid_q <= 1'b0;
				end else begin
					ph_q <= nxt_ph;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte = tx_byte_q;
	assign frame_bits = {1'b1, tx_byte_q, 1'b0};
	assign byte_role = role_q;
	assign last_of_run = last_q;
	assign stream_done = done_q;

endmodule

// ===== design/aligned_record_boot_framer.sv =====
// Top level of the aligned record boot framer: front end, command queue, byte emitter.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall    data_byte
//   out      source     out_valid / out_stall  tx_byte, frame_bits, byte_role,
//                                              last_of_run, stream_done
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front end takes one program byte per cycle while the command queue has room.
// The emitter sends one stream byte per cycle while out_stall is low; an item causes
// as many stream bytes as its groups hold: 1 for a plain data byte, up to 11 for the first one.
// A load_address write before the stream starts holds in_stall high for one cycle
// while the address offset within the record alignment is worked out. Reset is
// asynchronous, active low, and leaves the block ready at once. A stalled output
// holds its byte while the queue keeps accepting commands.
module aligned_record_boot_framer import arbf_pkg::*; #(
	parameter int RECORD_ALIGN = DEFAULT_RECORD_ALIGN,
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             tx_byte,
	output logic [9:0]             frame_bits,
	output logic [2:0]             byte_role,
	output logic                   last_of_run,
	output logic                   stream_done,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data
);

	logic q_full;
	logic q_push;
	cmd_t push_cmd;
	logic q_pop;
	logic q_avail;
	cmd_t head_cmd;

	assign cfg_ready = 1'b1;

	arbf_front #(
		.RECORD_ALIGN(RECORD_ALIGN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	arbf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.avail   (q_avail),
		.head_cmd(head_cmd)
	);

	arbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_byte    (tx_byte),
		.frame_bits (frame_bits),
		.byte_role  (byte_role),
		.last_of_run(last_of_run),
		.stream_done(stream_done)
	);

endmodule

// ===== design/arbf_checker.sv =====
// Port-level checks on the framer output stream, bound to the top level.
module arbf_checker import arbf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] tx_byte,
	input logic [9:0] frame_bits,
	input logic [2:0] byte_role,
	input logic       last_of_run,
	input logic       stream_done
);

	// A stalled transaction keeps its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte))
	else $error("stalled output byte changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_bits == {1'b1, tx_byte, 1'b0})
	else $error("frame bits do not match the byte");

	// The final byte of the stream is the end mark J and closes its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |->
			last_of_run && byte_role == ROLE_END && tx_byte == CHAR_J)
	else $error("stream end flagged on a wrong byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role == ROLE_LEADER |-> tx_byte == CHAR_LEADER && !last_of_run)
	else $error("leader byte is malformed");

endmodule

bind aligned_record_boot_framer arbf_checker u_arbf_checker (.*);
